// ----- src/ros_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ros_pkg
// Shared types and constants for the room separation block.
// ----------------------------------------------------------------------------
package ros_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned IterW  = 10;
  localparam int unsigned PadW   = 16;
  localparam int unsigned MultW  = 12;
  localparam int unsigned AreaW  = 32;
  localparam int unsigned SumW   = 38;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgAddrW-1:0] RegMaxIter = 2'd0;
  localparam logic [CfgAddrW-1:0] RegPadding = 2'd1;
  localparam logic [CfgAddrW-1:0] RegMainMul = 2'd2;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic [SizeW-1:0]         size_x;
    logic [SizeW-1:0]         size_y;
    logic                     last_room;
  } in_beat_t;

  typedef struct packed {
    logic [IdxW-1:0]          room_index;
    logic signed [CoordW-1:0] new_center_x;
    logic signed [CoordW-1:0] new_center_y;
    logic                     is_main;
    logic                     last_result;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RD_I,
    ST_RD_J,
    ST_PAIR,
    ST_WR_I,
    ST_WR_J,
    ST_NEXT,
    ST_OUT_RD,
    ST_OUT_CMP,
    ST_OUT_EMIT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic            load;
    logic            rd_i;
    logic            rd_j;
    logic            pair;
    logic            wr_i;
    logic            wr_j;
    logic            out_rd;
    logic            out_cmp;
    logic            clear;
    logic [IdxW-1:0] idx_i;
    logic [IdxW-1:0] idx_j;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       hit;
    logic [6:0] count;
  } dp_sts_t;

endpackage

// ----- src/ros_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ros_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ros_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ----- src/ros_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ros_datapath
// Room store, pair overlap test and push, and main room test.
// ----------------------------------------------------------------------------
module ros_datapath #(
  parameter int unsigned MaxRooms = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ros_pkg::in_beat_t                in_i,
  input  logic [ros_pkg::PadW-1:0]         padding_i,
  input  logic [ros_pkg::MultW-1:0]        mult_i,
  input  ros_pkg::dp_cmd_t                 cmd_i,
  output ros_pkg::dp_sts_t                 sts_o,
  output logic signed [ros_pkg::CoordW-1:0] cx_o,
  output logic signed [ros_pkg::CoordW-1:0] cy_o,
  output logic                             main_o
);
  localparam int unsigned RecW = 2 * ros_pkg::CoordW + 2 * ros_pkg::SizeW;
  localparam int unsigned AW   = $clog2(MaxRooms);
  localparam int unsigned CmpW = ros_pkg::SumW + ros_pkg::MultW;
  localparam logic signed [26:0] CMax = 27'sd8388607;
  localparam logic signed [26:0] CMin = -27'sd8388608;

  logic [6:0]                 count_q;
  logic [ros_pkg::SumW-1:0]   sum_q;
  logic                       hit_q;
  logic [RecW-1:0]            ram_wd, ram_rd;
  logic [AW-1:0]              addr;
  logic                       we;
  logic signed [ros_pkg::CoordW-1:0] cxi_q, cyi_q, cxj_q, cyj_q;
  logic [ros_pkg::SizeW-1:0]  wi_q, hi_q, wj_q, hj_q;
  logic [ros_pkg::AreaW-1:0]  area_q;
  logic                       main_q;

  // Pair geometry.
  logic signed [25:0] dx, dy, adx, ady;
  logic signed [27:0] ox2, oy2, push;
  logic signed [26:0] ni, nj;
  logic [ros_pkg::SizeW-1:0]  wj, hj;
  logic signed [ros_pkg::CoordW-1:0] cxj, cyj;
  logic signed [ros_pkg::CoordW-1:0] cxi_d, cyi_d, cxj_d, cyj_d;
  logic                       ovl, use_x, neg;

  // Room j arrives straight from the store while the pair is evaluated.
  assign {cxj, cyj, wj, hj} = ram_rd;

  function automatic logic signed [ros_pkg::CoordW-1:0] sat(input logic signed [26:0] v);
    if (v > CMax) begin
      return CMax[ros_pkg::CoordW-1:0];
    end else if (v < CMin) begin
      return CMin[ros_pkg::CoordW-1:0];
    end
    return v[ros_pkg::CoordW-1:0];
  endfunction

  always_comb begin
    dx  = 26'(cxj) - 26'(cxi_q);
    dy  = 26'(cyj) - 26'(cyi_q);
    adx = dx[25] ? -dx : dx;
    ady = dy[25] ? -dy : dy;
    ox2 = 28'(wi_q) + 28'(wj) + 28'({padding_i, 1'b0}) - 28'({adx, 1'b0});
    oy2 = 28'(hi_q) + 28'(hj) + 28'({padding_i, 1'b0}) - 28'({ady, 1'b0});
    ovl   = (ox2 > 0) && (oy2 > 0);
    use_x = ox2 < oy2;
    push  = use_x ? ((ox2 + 28'sd3) >>> 2) : ((oy2 + 28'sd3) >>> 2);
    neg   = use_x ? dx[25] : dy[25];
    if (neg) begin
      push = -push;
    end
    cxi_d = cxi_q;
    cyi_d = cyi_q;
    cxj_d = cxj;
    cyj_d = cyj;
    if (use_x) begin
      ni = 27'(cxi_q) - 27'(push);
      nj = 27'(cxj) + 27'(push);
      cxi_d = sat(ni);
      cxj_d = sat(nj);
    end else begin
      ni = 27'(cyi_q) - 27'(push);
      nj = 27'(cyj) + 27'(push);
      cyi_d = sat(ni);
      cyj_d = sat(nj);
    end
  end

  always_comb begin
    we     = 1'b0;
    addr   = cmd_i.idx_i[AW-1:0];
    ram_wd = {cxi_q, cyi_q, wi_q, hi_q};
    if (cmd_i.load) begin
      we     = count_q < 7'(MaxRooms);
      addr   = count_q[AW-1:0];
      ram_wd = {in_i.center_x, in_i.center_y, in_i.size_x, in_i.size_y};
    end else if (cmd_i.rd_j) begin
      addr = cmd_i.idx_j[AW-1:0];
    end else if (cmd_i.wr_i) begin
      we = 1'b1;
    end else if (cmd_i.wr_j) begin
      we     = 1'b1;
      addr   = cmd_i.idx_j[AW-1:0];
      ram_wd = {cxj_q, cyj_q, wj_q, hj_q};
    end
  end

  ros_ram #(.Width(RecW), .Depth(1 << AW)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(ram_wd), .rdata_o(ram_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
        sum_q   <= '0;
      end else if (cmd_i.load && count_q < 7'(MaxRooms)) begin
        count_q <= count_q + 7'd1;
        sum_q   <= sum_q + ros_pkg::SumW'(in_i.size_x * in_i.size_y);
      end
      if (cmd_i.rd_i && cmd_i.idx_i == '0 && cmd_i.idx_j == '0) begin
        hit_q <= 1'b0;
      end else if (cmd_i.pair && ovl) begin
        hit_q <= 1'b1;
      end
    end
  end

  logic [CmpW-1:0] lhs, rhs;
  assign lhs = CmpW'(area_q) * CmpW'(count_q) << 8;
  assign rhs = CmpW'(sum_q) * CmpW'(mult_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_j || cmd_i.out_rd) begin
      {cxi_q, cyi_q, wi_q, hi_q} <= ram_rd;
    end else if (cmd_i.pair && ovl) begin
      cxi_q <= cxi_d;
      cyi_q <= cyi_d;
    end
    if (cmd_i.pair) begin
      cxj_q <= ovl ? cxj_d : cxj;
      cyj_q <= ovl ? cyj_d : cyj;
      wj_q  <= wj;
      hj_q  <= hj;
    end
    if (cmd_i.out_rd) begin
      area_q <= ram_rd[31:16] * ram_rd[15:0];
    end
    if (cmd_i.out_cmp) begin
      main_q <= lhs >= rhs;
    end
  end

  assign sts_o.hit   = hit_q;
  assign sts_o.count = count_q;
  assign cx_o   = cxi_q;
  assign cy_o   = cyi_q;
  assign main_o = main_q;

  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 7'(MaxRooms)) else $error("room count over bound");
  ap_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> count_q == '0 && sum_q == '0) else $error("clear failed");
  ap_onewr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.wr_i && cmd_i.wr_j)) else $error("double write");
endmodule

// ----- src/ros_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ros_ctrl
// Sequencer for loading, relaxation passes and result emission.
// ----------------------------------------------------------------------------
module ros_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_last_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_last_o,
  output logic [ros_pkg::IdxW-1:0]    out_idx_o,
  input  logic [ros_pkg::IterW-1:0]   max_iter_i,
  output ros_pkg::dp_cmd_t            cmd_o,
  input  ros_pkg::dp_sts_t            sts_i
);
  ros_pkg::state_e state_q, state_d;
  logic [ros_pkg::IdxW-1:0]  i_q, i_d, j_q, j_d;
  logic [ros_pkg::IterW-1:0] it_q, it_d;
  logic [6:0] n;
  logic       last_i, last_j;

  assign n      = sts_i.count;
  assign last_j = 7'(j_q) + 7'd1 >= n;
  assign last_i = 7'(i_q) + 7'd2 >= n;

  always_comb begin
    state_d = state_q;
    i_d = i_q;
    j_d = j_q;
    it_d = it_q;
    unique case (state_q)
      ros_pkg::ST_LOAD: begin
        if (in_valid_i && in_last_i) begin
          i_d = '0;
          j_d = ros_pkg::IdxW'(1);
          it_d = '0;
          state_d = ros_pkg::ST_NEXT;
        end
      end
      ros_pkg::ST_NEXT: begin
        // Start of a pass: decide whether another one runs.
        if (n < 7'd2 || it_q >= max_iter_i || (it_q != '0 && !sts_i.hit)) begin
          i_d = '0;
          state_d = (n == '0) ? ros_pkg::ST_LOAD : ros_pkg::ST_OUT_RD;
        end else begin
          i_d = '0;
          j_d = ros_pkg::IdxW'(1);
          state_d = ros_pkg::ST_RD_I;
        end
      end
      ros_pkg::ST_RD_I: state_d = ros_pkg::ST_RD_J;
      ros_pkg::ST_RD_J: state_d = ros_pkg::ST_PAIR;
      ros_pkg::ST_PAIR: state_d = ros_pkg::ST_WR_I;
      ros_pkg::ST_WR_I: state_d = ros_pkg::ST_WR_J;
      ros_pkg::ST_WR_J: begin
        state_d = ros_pkg::ST_RD_I;
        if (!last_j) begin
          j_d = j_q + 1'b1;
        end else if (!last_i) begin
          i_d = i_q + 1'b1;
          j_d = i_q + ros_pkg::IdxW'(2);
        end else begin
          it_d = it_q + 1'b1;
          state_d = ros_pkg::ST_NEXT;
        end
      end
      ros_pkg::ST_OUT_RD: state_d = ros_pkg::ST_OUT_CMP;
      ros_pkg::ST_OUT_CMP: state_d = ros_pkg::ST_OUT_EMIT;
      ros_pkg::ST_OUT_EMIT: begin
        if (out_ready_i) begin
          if (7'(i_q) + 7'd1 >= n) begin
            state_d = ros_pkg::ST_LOAD;
          end else begin
            i_d = i_q + 1'b1;
            state_d = ros_pkg::ST_OUT_RD;
          end
        end
      end
      default: state_d = ros_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.idx_i = i_q;
    cmd_o.idx_j = j_q;
    in_ready_o  = state_q == ros_pkg::ST_LOAD;
    out_valid_o = state_q == ros_pkg::ST_OUT_EMIT;
    out_last_o  = 7'(i_q) + 7'd1 >= n;
    out_idx_o   = i_q;
    unique case (state_q)
      ros_pkg::ST_LOAD:  cmd_o.load = in_valid_i;
      // The start of a pass clears the overlap flag (idx_i and idx_j zero here).
      // Index zero is also the read address for the first result.
      ros_pkg::ST_NEXT:  begin
        cmd_o.rd_i  = 1'b1;
        cmd_o.idx_i = '0;
        cmd_o.idx_j = '0;
      end
      ros_pkg::ST_RD_I:  cmd_o.rd_i = 1'b0;
      ros_pkg::ST_RD_J:  cmd_o.rd_j = 1'b1;
      ros_pkg::ST_PAIR:  cmd_o.pair = 1'b1;
      ros_pkg::ST_WR_I:  cmd_o.wr_i = 1'b1;
      ros_pkg::ST_WR_J:  cmd_o.wr_j = 1'b1;
      ros_pkg::ST_OUT_RD:  cmd_o.out_rd = 1'b1;
      ros_pkg::ST_OUT_CMP: cmd_o.out_cmp = 1'b1;
      // The next room's read is issued while the current beat leaves.
      ros_pkg::ST_OUT_EMIT: begin
        cmd_o.idx_i = i_d;
        cmd_o.clear = out_ready_i && out_last_o;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ros_pkg::ST_LOAD;
      i_q <= '0;
      j_q <= '0;
      it_q <= '0;
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      j_q <= j_d;
      it_q <= it_d;
    end
  end

  ap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ros_pkg::ST_PAIR |-> i_q < j_q) else $error("pair order broken");
  ap_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(i_q)) else $error("result dropped");
  ap_noload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("load during emit");
endmodule

// ----- src/rect_overlap_separation_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_overlap_separation_top
// Pushes overlapping rooms apart and marks the main rooms.
// ----------------------------------------------------------------------------
// Rooms arrive as input beats, one per cycle while in_ready_o is high, up to
// MaxRooms; extra rooms are dropped. The beat with last_room set starts the
// relaxation, during which in_ready_o stays low. Each pass visits every pair
// i<j through one shared store port, reading room i, reading room j, testing
// the pair for overlap and writing both rooms back; up to max_iterations passes
// run, fewer when a pass finds no overlap. Then one result beat per room leaves
// in index order, each read and compared before it is offered; a stalled
// receiver simply holds the beat. After the final result the block loads a new set.
// Reset empties the room set and restores the register defaults (50 passes,
// padding 1.0, multiplier 1.25). Registers are written through cfg_we_i.
// ----------------------------------------------------------------------------
module rect_overlap_separation_top #(
  parameter int unsigned MaxRooms = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ros_pkg::in_beat_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ros_pkg::out_beat_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [ros_pkg::CfgAddrW-1:0]        cfg_addr_i,
  input  logic [ros_pkg::CfgDataW-1:0]        cfg_data_i
);
  logic [ros_pkg::IterW-1:0] max_iter_q;
  logic [ros_pkg::PadW-1:0]  pad_q;
  logic [ros_pkg::MultW-1:0] mult_q;
  ros_pkg::dp_cmd_t cmd;
  ros_pkg::dp_sts_t sts;
  logic out_last;
  logic [ros_pkg::IdxW-1:0] out_idx;
  logic signed [ros_pkg::CoordW-1:0] cx, cy;
  logic is_main;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= 10'd50;
      pad_q      <= 16'd256;
      mult_q     <= 12'd320;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ros_pkg::RegMaxIter: max_iter_q <= cfg_data_i[ros_pkg::IterW-1:0];
        ros_pkg::RegPadding: pad_q      <= cfg_data_i;
        ros_pkg::RegMainMul: mult_q     <= cfg_data_i[ros_pkg::MultW-1:0];
        default: ;
      endcase
    end
  end

  ros_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_last_i(in_data_i.last_room), .in_ready_o,
    .out_valid_o, .out_ready_i, .out_last_o(out_last), .out_idx_o(out_idx),
    .max_iter_i(max_iter_q), .cmd_o(cmd), .sts_i(sts)
  );

  ros_datapath #(.MaxRooms(MaxRooms)) u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .padding_i(pad_q), .mult_i(mult_q),
    .cmd_i(cmd), .sts_o(sts), .cx_o(cx), .cy_o(cy), .main_o(is_main)
  );

  always_comb begin
    out_data_o.room_index   = out_idx;
    out_data_o.new_center_x = cx;
    out_data_o.new_center_y = cy;
    out_data_o.is_main      = is_main;
    out_data_o.last_result  = out_last;
  end
endmodule
